### sv/fmb_pkg.sv
// Shared types and constants for the E4M3 x E4M3 to bfloat16 multiplier.
package fmb_pkg;
  localparam logic [15:0] BF16_QNAN = 16'h7FC0;
  localparam logic [6:0] E4M3_NAN_MAG = 7'h7F;
  localparam logic [7:0] REBIAS = 8'h71;

  // Unpacked operand after stage 1.
  typedef struct packed {
    logic [4:0] exp;  // signed, -2..15
    logic [3:0] sig;  // 8..15
  } fmb_unp_t;

  // Special-case flags that travel with each beat.
  typedef struct packed {
    logic nan;
    logic zero;
    logic sign;
  } fmb_flags_t;
endpackage

### sv/fmb_if.sv
// Valid/ready channel interfaces for the multiplier.
interface fmb_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] a_bits;
  logic [7:0] b_bits;
  modport source (output valid, a_bits, b_bits, input ready);
  modport sink (input valid, a_bits, b_bits, output ready);
endinterface

interface fmb_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [15:0] product_bits;
  modport source (output valid, product_bits, input ready);
  modport sink (input valid, product_bits, output ready);
endinterface

### sv/fmb_unpack.sv
// Stage 1 logic: classify and normalize one E4M3 operand.
module fmb_unpack (
  input  logic [7:0] bits,
  output fmb_pkg::fmb_unp_t unp,
  output logic is_nan,
  output logic is_zero
);
  import fmb_pkg::*;

  // Classify the operand, then leading-one normalize a subnormal fraction
  always_comb begin
    is_nan = (bits[6:0] == E4M3_NAN_MAG);
    is_zero = (bits[6:0] == 7'd0);
    unp.exp = {1'b0, bits[6:3]};
    unp.sig = {1'b1, bits[2:0]};
    if (bits[6:3] == 4'd0) begin
      if (bits[2]) begin
        unp.exp = 5'd0;
        unp.sig = {1'b1, bits[1:0], 1'b0};
      end else if (bits[1]) begin
        unp.exp = 5'h1F;
        unp.sig = {1'b1, bits[0], 2'b0};
      end else begin
        unp.exp = 5'h1E;
        unp.sig = 4'b1000;
      end
    end
  end
endmodule

### sv/fp8_e4m3_mul_to_bf16_top.sv
// Three-stage E4M3 x E4M3 widening multiplier into bfloat16.
// An accepted input beat is registered in stage 1, stage 2 and stage 3 before output valid.
// Throughput: one beat per cycle while out_ch.ready holds; unpack, multiply, pack are one stage each.
// Stalls hold each valid stage whose successor is held, a bubble stage is filled while stalled.
// Reset clears the stage valid bits; data registers are not reset.
module fp8_e4m3_mul_to_bf16_top (
  input logic clk,
  input logic rst,
  fmb_in_if.sink in_ch,
  fmb_out_if.source out_ch
);
  import fmb_pkg::*;

  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  fmb_unp_t ua, ub, ua1, ub1;
  logic na, nb, za, zb;
  fmb_flags_t f1, f2;
  logic [7:0] p2;
  logic [7:0] e2;
  logic [15:0] res3;
  logic [7:0] ez;
  logic [6:0] frac;

  // Stall control: a stage moves when it is empty or the one after it can take the beat
  assign adv3 = !v3 || out_ch.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ch.ready = adv1;

  fmb_unpack u_a (.bits(in_ch.a_bits), .unp(ua), .is_nan(na), .is_zero(za));
  fmb_unpack u_b (.bits(in_ch.b_bits), .unp(ub), .is_nan(nb), .is_zero(zb));

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_ch.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1: unpacked operands
  always_ff @(posedge clk) begin
    if (adv1) begin
      ua1 <= ua;
      ub1 <= ub;
      f1 <= '{nan: na || nb, zero: za || zb,
              sign: in_ch.a_bits[7] ^ in_ch.b_bits[7]};
    end
  end

  // Stage 2: significand multiply and exponent sum
  always_ff @(posedge clk) begin
    if (adv2) begin
      p2 <= {4'd0, ua1.sig} * {4'd0, ub1.sig};
      e2 <= {{3{ua1.exp[4]}}, ua1.exp} + {{3{ub1.exp[4]}}, ub1.exp} + REBIAS;
      f2 <= f1;
    end
  end

  // Stage 3: normalize and pack
  always_comb begin
    ez = e2 + {7'd0, p2[7]};
    frac = p2[7] ? p2[6:0] : {p2[5:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      if (f2.nan) res3 <= BF16_QNAN;
      else if (f2.zero) res3 <= {f2.sign, 15'd0};
      else res3 <= {f2.sign, ez, frac};
    end
  end

  assign out_ch.valid = v3;
  assign out_ch.product_bits = res3;
endmodule
